>>> design/bc_pkg.sv
// ----------------------------------------------------------------------------
// bc_pkg: shared types and constants for the binomial coefficient pipeline
// Sizes of the Pascal row carried down the pipeline and the item record.
// ----------------------------------------------------------------------------
`default_nettype none

package bc_pkg;

	// Largest degree served; one row-build stage per degree step
	localparam int MAX_DEGREE  = 32;
	localparam int NUM_ENTRIES = MAX_DEGREE + 1;
	localparam int NUM_STAGES  = MAX_DEGREE;

	// Field widths of the request and the response
	localparam int IDX_W  = 6;
	localparam int COEF_W = 30;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [COEF_W-1:0] coef_t;

	// One request in flight together with its partial Pascal row
	typedef struct packed {
		idx_t                     degree;
		idx_t                     term_index;
		logic                     out_of_range;
		coef_t [NUM_ENTRIES-1:0]  row;
	} item_t;

endpackage

`default_nettype wire

>>> design/bc_req_if.sv
// ----------------------------------------------------------------------------
// bc_req_if: request channel
// Carries degree and term index with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bc_req_if
	import bc_pkg::*;
();
	logic valid;
	logic ready;
	idx_t degree;
	idx_t term_index;

	modport source (output valid, output degree, output term_index, input ready);
	modport sink   (input valid, input degree, input term_index, output ready);
endinterface

`default_nettype wire

>>> design/bc_rsp_if.sv
// ----------------------------------------------------------------------------
// bc_rsp_if: response channel
// Carries the coefficient and the range error flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bc_rsp_if
	import bc_pkg::*;
();
	logic  valid;
	logic  ready;
	coef_t coefficient;
	logic  out_of_range;

	modport source (output valid, output coefficient, output out_of_range, input ready);
	modport sink   (input valid, input coefficient, input out_of_range, output ready);
endinterface

`default_nettype wire

>>> design/bc_row_stage.sv
// ----------------------------------------------------------------------------
// bc_row_stage: one Pascal row step
// Turns row r-1 into row r when r does not exceed the item's degree, else
// passes the row through untouched; one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_row_stage
	import bc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  advance,
	input  wire idx_t  row_num,
	input  wire logic  in_valid,
	input  wire item_t in_item,
	output logic       out_valid,
	output item_t      out_item
);

	item_t nxt_item;
	logic  valid_s1;
	item_t item_s1;

	// Add each entry to its left neighbor; the left edge stays 1
	always_comb begin
		nxt_item = in_item;
		if (row_num <= in_item.degree) begin
			for (int j = 1; j < NUM_ENTRIES; j++) begin
				nxt_item.row[j] = in_item.row[j] + in_item.row[j-1];
			end
		end
	end

	// Advance the valid bit with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Advance the payload; hold it on a stall
	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= nxt_item;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

`default_nettype wire

>>> design/bc_select.sv
// ----------------------------------------------------------------------------
// bc_select: coefficient pick and output register
// Picks entry k of the finished row, forces 0 for a range error, and holds
// the response until the sink takes the transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_select
	import bc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire item_t in_item,
	output logic       advance,
	bc_rsp_if.source   rsp
);

	coef_t pick;
	logic  valid_q;
	coef_t coefficient_q;
	logic  out_of_range_q;

	// Move the whole pipeline when the output slot is empty or being taken
	assign advance = !valid_q || rsp.ready;

	// Select entry k; a range error reads as 0
	always_comb begin
		pick = '0;
		if (!in_item.out_of_range) begin
			for (int j = 0; j < NUM_ENTRIES; j++) begin
				if (idx_t'(j) == in_item.term_index) begin
					pick = in_item.row[j];
				end
			end
		end
	end

	// Hold the response valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			coefficient_q  <= pick;
			out_of_range_q <= in_item.out_of_range;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.coefficient  = coefficient_q;
	assign rsp.out_of_range = out_of_range_q;

endmodule

`default_nettype wire

>>> design/binomial_coefficient_top.sv
// ----------------------------------------------------------------------------
// binomial_coefficient_top: binomial coefficient C(n,k) by Pascal rows
// A row vector flows down one stage per degree step; the last stage picks
// entry k and registers the response.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   degree[5:0], term_index[5:0]
//   rsp      out  valid/ready   coefficient[29:0], out_of_range
//
// One request enters per cycle while rsp is not stalled; each response passes
// the 32 row stages and then the output register, a depth set by MAX_DEGREE.
// Every request takes the full depth, whatever its degree.
// Reset clears all valid bits; payload registers are not reset.
// A stall on rsp freezes every stage at once; req.ready is low meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_coefficient_top
	import bc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	bc_req_if.sink    req,
	bc_rsp_if.source  rsp
);

	logic  advance;
	item_t seed_item;
	logic  stage_valid [NUM_STAGES+1];
	item_t stage_item  [NUM_STAGES+1];

	// Seed row zero and flag a bad request on entry
	always_comb begin
		seed_item              = '0;
		seed_item.degree       = req.degree;
		seed_item.term_index   = req.term_index;
		seed_item.out_of_range = (req.degree > idx_t'(MAX_DEGREE))
			|| (req.term_index > req.degree);
		seed_item.row[0]       = coef_t'(1);
	end

	assign stage_item[0]  = seed_item;
	assign stage_valid[0] = req.valid;
	assign req.ready      = advance;

	// Build rows one through MAX_DEGREE
	for (genvar g = 1; g <= NUM_STAGES; g++) begin : g_row
		bc_row_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.row_num   (idx_t'(g)),
			.in_valid  (stage_valid[g-1]),
			.in_item   (stage_item[g-1]),
			.out_valid (stage_valid[g]),
			.out_item  (stage_item[g])
		);
	end

	// Pick the coefficient and drive the response
	bc_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stage_valid[NUM_STAGES]),
		.in_item  (stage_item[NUM_STAGES]),
		.advance  (advance),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

>>> verif/bc_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc_scoreboard_pkg: coefficient predictor and response checker
// Keeps a private Pascal row, predicts C(n,k) with its range flag for every
// accepted request, and compares each response with the oldest prediction.
// ----------------------------------------------------------------------------

package bc_scoreboard_pkg;
	import bc_pkg::*;

	// One predicted response
	typedef struct {
		coef_t coefficient;
		logic  out_of_range;
	} coef_result_t;

	class coefficient_scoreboard;
		localparam logic [31:0] COEF_LIMIT = (32'd1 << COEF_W) - 32'd1;
		localparam int          MAX_REPORTED = 50;

		// Private copy of the block state
		logic [31:0]  pascal_row [NUM_ENTRIES];
		idx_t         last_degree = '0;
		idx_t         last_index  = '0;

		coef_result_t expected_coefs [$];
		int           mismatches     = 0;
		int           responses_seen = 0;

		// Print one line per mismatch, keep counting past the print cap
		task report_mismatch(input string msg);
			if (mismatches < MAX_REPORTED)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			mismatches++;
		endtask

		// Build rows 0..n in place and read entry k
		function coef_result_t predict_coefficient(input idx_t n, input idx_t k);
			coef_result_t res;
			logic [31:0]  value;
			int           r;
			int           j;
			last_degree = n;
			last_index  = k;
			res.coefficient  = '0;
			res.out_of_range = 1'b1;
			if (int'(n) <= MAX_DEGREE && k <= n) begin
				for (r = 0; r <= int'(n); r++) begin
					pascal_row[r] = 32'd1;
					for (j = r; j > 1; j--)
						pascal_row[j-1] = pascal_row[j-1] + pascal_row[j-2];
					pascal_row[0] = 32'd1;
				end
				value = pascal_row[k];
				if (value > COEF_LIMIT)
					value = COEF_LIMIT;
				res.coefficient  = value[COEF_W-1:0];
				res.out_of_range = 1'b0;
			end
			return res;
		endfunction

		// Note an accepted request transaction
		function void note_request(input idx_t n, input idx_t k);
			expected_coefs.push_back(predict_coefficient(n, k));
		endfunction

		// Check an accepted response transaction against the oldest prediction
		task check_response(input coef_t coefficient, input logic out_of_range);
			coef_result_t want;
			responses_seen++;
			if (expected_coefs.size() == 0) begin
				report_mismatch($sformatf("response %0d arrived with no request pending",
					responses_seen));
			end else begin
				want = expected_coefs.pop_front();
				if (coefficient !== want.coefficient)
					report_mismatch($sformatf("response %0d coefficient got %0d want %0d",
						responses_seen, coefficient, want.coefficient));
				if (out_of_range !== want.out_of_range)
					report_mismatch($sformatf("response %0d out_of_range got %b want %b",
						responses_seen, out_of_range, want.out_of_range));
			end
		endtask

		function int pending();
			return expected_coefs.size();
		endfunction
	endclass

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the binomial coefficient block
// Drives degree/term index requests (directed corners, then mostly valid
// random requests mixed with out-of-range noise) under bursty sender and
// stalling receiver patterns, and checks every response in order.
// ----------------------------------------------------------------------------

module tb_top;
	import bc_pkg::*;
	import bc_scoreboard_pkg::*;

	localparam int RANDOM_ITEMS  = 1040;
	localparam int PRESSURE_ITEMS = 70;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 400000;

	typedef enum int {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   hold_request = 1'b0;
	int   cycle_count  = 0;

	coefficient_scoreboard coef_board = new();

	bc_req_if req_ch ();
	bc_rsp_if rsp_ch ();

	binomial_coefficient_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Check every accepted response transaction
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			coef_board.check_response(rsp_ch.coefficient, rsp_ch.out_of_range);
	end

	// Receiver: pick a new random stall mode when the current one runs out, honor a long hold-off
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		mode      = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					RX_FREE: begin
						rsp_ch.ready = 1'b1;
					end
					RX_MOSTLY: begin
						rsp_ch.ready = ($urandom_range(0, 3) != 0);
					end
					RX_SPARSE: begin
						rsp_ch.ready = ($urandom_range(0, 3) == 0);
					end
					default: begin
						rsp_ch.ready = mode_left[1];
					end
				endcase
			end
		end
	end

	// Offer one request and hold it until accepted
	task automatic send_request(input idx_t n, input idx_t k);
		bit accepted;
		req_ch.degree     = n;
		req_ch.term_index = k;
		req_ch.valid      = 1'b1;
		do begin
			@(posedge clk);
			accepted = req_ch.ready;
		end while (!accepted);
		coef_board.note_request(n, k);
		@(negedge clk);
	endtask

	// Drop valid for a gap
	task automatic idle_cycles(input int n);
		req_ch.valid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Pause the sender until every expected response has come back
	task automatic wait_drained();
		req_ch.valid = 1'b0;
		while (coef_board.pending() != 0)
			@(negedge clk);
	endtask

	// Mostly well-formed requests, some index-above-degree, some full-range noise
	task automatic random_request(output idx_t n, output idx_t k);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 80) begin
			n = idx_t'($urandom_range(0, MAX_DEGREE));
			k = idx_t'($urandom_range(0, n));
		end else if (sel < 90) begin
			n = idx_t'($urandom_range(0, MAX_DEGREE));
			k = idx_t'($urandom_range(int'(n) + 1, (1 << IDX_W) - 1));
		end else begin
			n = idx_t'($urandom);
			k = idx_t'($urandom);
		end
	endtask

	// Send random requests in bursts, with random gaps between bursts when allow_gaps is set
	task automatic random_bursts(input int count, input bit allow_gaps);
		idx_t n;
		idx_t k;
		int   burst;
		int   i;
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			for (i = 0; i < burst && count > 0; i++) begin
				random_request(n, k);
				send_request(n, k);
				count--;
			end
			if (allow_gaps && $urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 6));
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.degree     = '0;
		req_ch.term_index = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_cycles(2);

		// Corners: edges, middle of the widest row, invalid requests
		send_request(6'd0, 6'd0);
		send_request(6'd1, 6'd0);
		send_request(6'd1, 6'd1);
		send_request(6'd2, 6'd1);
		send_request(6'd32, 6'd0);
		send_request(6'd32, 6'd32);
		send_request(6'd32, 6'd16);
		send_request(6'd32, 6'd15);
		send_request(6'd32, 6'd17);
		send_request(6'd31, 6'd15);
		send_request(6'd20, 6'd10);
		send_request(6'd16, 6'd8);
		send_request(6'd10, 6'd3);
		// Index above degree
		send_request(6'd5, 6'd6);
		send_request(6'd0, 6'd1);
		send_request(6'd32, 6'd33);
		send_request(6'd0, 6'd63);
		// Degree above the maximum, then one valid request
		send_request(6'd33, 6'd0);
		send_request(6'd40, 6'd20);
		send_request(6'd63, 6'd0);
		send_request(6'd63, 6'd63);
		send_request(6'd32, 6'd31);

		// Let the pipeline empty, then hold the receiver off while flooding
		wait_drained();
		hold_request = 1'b1;
		random_bursts(PRESSURE_ITEMS, 1'b0);

		// Main random phase
		random_bursts(RANDOM_ITEMS, 1'b1);

		// Drain and settle
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (coef_board.pending() != 0)
			coef_board.report_mismatch($sformatf("%0d responses never arrived",
				coef_board.pending()));
		if (coef_board.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
